[sv/rcit_pkg.sv]
// Shared types and codes for the refcounted ID interning table.
// No dependencies; used by the table top level and its port checker.
package rcit_pkg;

    typedef logic [1:0] op_t;
    typedef logic [1:0] status_t;

    // Request operation codes
    localparam op_t OP_CACHE  = 2'd0;
    localparam op_t OP_FORGET = 2'd1;
    localparam op_t OP_LOOKUP = 2'd2;
    localparam op_t OP_CLEAR  = 2'd3;

    // Response status codes
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_OVERFLOW  = 2'd3;

    // Fixed port field widths
    localparam int KEY_PORT_W   = 32;
    localparam int ID_PORT_W    = 6;
    localparam int COUNT_PORT_W = 16;
    localparam int CACHED_W     = 7;

endpackage

[sv/rcit_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; one instance holds the key and count of every slot.
module rcit_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/refcounted_id_interning_table.sv]
// Refcounted ID interning table: top level with scan sequencer and response register.
// Depends on rcit_pkg (codes, field widths) and rcit_ram (slot key/count storage).
//
// Usage:
//   Request channel (req_valid / req_stall) carries op, key and query_id: cache a
//   key (intern or bump its count), forget a key (drop its count, free the slot
//   at zero), look up a slot ID, or clear the table.
//   Response channel (rsp_valid / rsp_stall) returns one response per request, in
//   order: ID, key and count held there, id_valid, status, hole and key counts.
//
// Sequencing, one request in flight at a time:
//   cache / forget : the scan reads one slot per cycle below the used length and
//                    stops at a hit, then a read-modify-write update; with an
//                    empty table the scan reads nothing and goes to the update.
//   lookup : RAM read, then response.   clear : straight to the update.
//   req_stall is low only while the sequencer is idle, so the next request waits
//   until the current one has written its response. A finished response waits in
//   the output register while the next request is accepted; if rsp_stall holds,
//   that op waits in its update state, committing nothing until the register frees.
//
// Reset: asynchronous, active low. Clears occupancy bits, used length, hole and
//   key counts, and the response valid. The slot RAM is not cleared; a slot's data is
//   only used after it has been written while occupied.
module refcounted_id_interning_table #(
    parameter int SLOTS      = 64,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  rcit_pkg::op_t                         op,
    input  logic [rcit_pkg::KEY_PORT_W-1:0]       key,
    input  logic [rcit_pkg::ID_PORT_W-1:0]        query_id,
    // response channel
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output logic [rcit_pkg::ID_PORT_W-1:0]        result_id,
    output logic [rcit_pkg::KEY_PORT_W-1:0]       result_key,
    output logic                                  id_valid,
    output rcit_pkg::status_t                     status,
    output logic [rcit_pkg::COUNT_PORT_W-1:0]     use_count,
    output logic [rcit_pkg::ID_PORT_W-1:0]        hole_count,
    output logic [rcit_pkg::CACHED_W-1:0]         cached_count
);

    localparam int ADDR_W = $clog2(SLOTS);
    localparam int LEN_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = (LEN_W > rcit_pkg::ID_PORT_W) ? LEN_W : rcit_pkg::ID_PORT_W;
    localparam int WORD_W = KEY_BITS + COUNT_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [LEN_W-1:0]      LEN_FULL  = LEN_W'(SLOTS);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    // control state
    logic [1:0]        state_reg, state_next;
    logic [SLOTS-1:0]  occ_reg, occ_next;
    logic [LEN_W-1:0]  used_reg, used_next;
    logic [LEN_W-1:0]  holes_reg, holes_next;
    logic [LEN_W-1:0]  dist_reg, dist_next;
    logic [LEN_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic              found_reg, found_next;
    logic              hole_found_reg, hole_found_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // request / scan payload
    rcit_pkg::op_t                op_reg, op_next;
    logic [KEY_BITS-1:0]          key_reg, key_next;
    logic [rcit_pkg::ID_PORT_W-1:0] qid_reg, qid_next;
    logic [ADDR_W-1:0]            chk_idx_reg, chk_idx_next;
    logic [ADDR_W-1:0]            slot_reg, slot_next;
    logic [ADDR_W-1:0]            hole_idx_reg, hole_idx_next;
    logic [COUNT_BITS-1:0]        cnt_reg, cnt_next;

    // response payload
    logic [rcit_pkg::ID_PORT_W-1:0]    res_id_reg, res_id_next;
    logic [KEY_BITS-1:0]               res_key_reg, res_key_next;
    logic                              res_vld_reg, res_vld_next;
    rcit_pkg::status_t                 res_st_reg, res_st_next;
    logic [COUNT_BITS-1:0]             res_cnt_reg, res_cnt_next;
    logic [LEN_W-1:0]                  res_holes_reg, res_holes_next;
    logic [LEN_W-1:0]                  res_dist_reg, res_dist_next;

    // RAM port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [KEY_BITS-1:0]   rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  req_fire;
    logic                  rsp_free;
    logic                  scan_more;
    logic [ADDR_W-1:0]     scan_addr;
    logic                  look_hit;
    logic [ADDR_W-1:0]     new_slot;
    logic                  new_ok;
    logic [COUNT_BITS-1:0] cnt_dec;

    rcit_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key    = ram_rdata[WORD_W-1:COUNT_BITS];
    assign rd_cnt    = ram_rdata[COUNT_BITS-1:0];
    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign scan_more = (scan_idx_reg < used_reg);
    assign scan_addr = scan_idx_reg[ADDR_W-1:0];
    assign cnt_dec   = cnt_reg - COUNT_BITS'(1);
    // lookup: ID below used length and slot occupied (slots at or past the
    // used length are never occupied)
    assign look_hit  = (CMP_W'(qid_reg) < CMP_W'(used_reg)) && occ_reg[ADDR_W'(qid_reg)];

    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        used_next       = used_reg;
        holes_next      = holes_reg;
        dist_next       = dist_reg;
        scan_idx_next   = scan_idx_reg;
        chk_vld_next    = chk_vld_reg;
        found_next      = found_reg;
        hole_found_next = hole_found_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        qid_next        = qid_reg;
        chk_idx_next    = chk_idx_reg;
        slot_next       = slot_reg;
        hole_idx_next   = hole_idx_reg;
        cnt_next        = cnt_reg;

        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        res_id_next     = res_id_reg;
        res_key_next    = res_key_reg;
        res_vld_next    = res_vld_reg;
        res_st_next     = res_st_reg;
        res_cnt_next    = res_cnt_reg;
        res_holes_next  = res_holes_reg;
        res_dist_next   = res_dist_reg;

        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata = {key_reg, cnt_reg};
        ram_re    = 1'b0;
        ram_raddr = scan_addr;
        new_slot  = hole_idx_reg;
        new_ok    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next         = op;
                    key_next        = KEY_BITS'(key);
                    qid_next        = query_id;
                    scan_idx_next   = '0;
                    chk_vld_next    = 1'b0;
                    found_next      = 1'b0;
                    hole_found_next = 1'b0;
                    unique case (op)
                        rcit_pkg::OP_CACHE,
                        rcit_pkg::OP_FORGET: state_next = S_SCAN;
                        rcit_pkg::OP_LOOKUP: state_next = S_LOOK;
                        rcit_pkg::OP_CLEAR:  state_next = S_UPD;
                        default:             state_next = S_UPD;
                    endcase
                end
            end

            S_LOOK:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ADDR_W'(qid_reg);
                state_next = S_UPD;
            end

            S_SCAN:
            begin
                // issue side: one read per cycle, note the lowest hole
                if (scan_more)
                begin
                    ram_re        = 1'b1;
                    scan_idx_next = scan_idx_reg + LEN_W'(1);
                    chk_idx_next  = scan_addr;
                    if (!occ_reg[scan_addr] && !hole_found_reg)
                    begin
                        hole_found_next = 1'b1;
                        hole_idx_next   = scan_addr;
                    end
                end
                chk_vld_next = scan_more;
                // compare side: data for chk_idx_reg is on the RAM output
                if (chk_vld_reg && occ_reg[chk_idx_reg] && (rd_key == key_reg))
                begin
                    found_next = 1'b1;
                    slot_next  = chk_idx_reg;
                    cnt_next   = rd_cnt;
                    state_next = S_UPD;
                end
                else if (!chk_vld_reg && !scan_more)
                begin
                    state_next = S_UPD;
                end
            end

            S_UPD:
            begin
                if (rsp_free)
                begin
                    res_id_next  = '0;
                    res_key_next = '0;
                    res_vld_next = 1'b0;
                    res_st_next  = rcit_pkg::ST_OK;
                    res_cnt_next = '0;

                    unique case (op_reg)
                        rcit_pkg::OP_CLEAR:
                        begin
                            occ_next   = '0;
                            used_next  = '0;
                            holes_next = '0;
                            dist_next  = '0;
                        end

                        rcit_pkg::OP_LOOKUP:
                        begin
                            res_id_next = qid_reg;
                            if (look_hit)
                            begin
                                res_vld_next = 1'b1;
                                res_key_next = rd_key;
                                res_cnt_next = rd_cnt;
                            end
                        end

                        rcit_pkg::OP_CACHE:
                        begin
                            if (found_reg)
                            begin
                                res_id_next  = rcit_pkg::ID_PORT_W'(slot_reg);
                                res_vld_next = 1'b1;
                                res_key_next = key_reg;
                                if (cnt_reg == COUNT_MAX)
                                begin
                                    res_st_next  = rcit_pkg::ST_OVERFLOW;
                                    res_cnt_next = cnt_reg;
                                end
                                else
                                begin
                                    ram_we       = 1'b1;
                                    ram_wdata    = {key_reg, cnt_reg + COUNT_BITS'(1)};
                                    res_cnt_next = cnt_reg + COUNT_BITS'(1);
                                end
                            end
                            else
                            begin
                                // new key: lowest hole first, else append
                                if (hole_found_reg)
                                begin
                                    new_slot   = hole_idx_reg;
                                    new_ok     = 1'b1;
                                    holes_next = holes_reg - LEN_W'(1);
                                end
                                else if (used_reg != LEN_FULL)
                                begin
                                    new_slot  = used_reg[ADDR_W-1:0];
                                    new_ok    = 1'b1;
                                    used_next = used_reg + LEN_W'(1);
                                end
                                if (new_ok)
                                begin
                                    ram_we             = 1'b1;
                                    ram_waddr          = new_slot;
                                    ram_wdata          = {key_reg, COUNT_BITS'(1)};
                                    occ_next[new_slot] = 1'b1;
                                    dist_next          = dist_reg + LEN_W'(1);
                                    res_id_next        = rcit_pkg::ID_PORT_W'(new_slot);
                                    res_vld_next       = 1'b1;
                                    res_key_next       = key_reg;
                                    res_cnt_next       = COUNT_BITS'(1);
                                end
                                else
                                begin
                                    res_st_next = rcit_pkg::ST_FULL;
                                end
                            end
                        end

                        rcit_pkg::OP_FORGET:
                        begin
                            if (!found_reg)
                            begin
                                res_st_next = rcit_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                res_id_next = rcit_pkg::ID_PORT_W'(slot_reg);
                                if (cnt_dec == '0)
                                begin
                                    // freed: tail slot shrinks the length,
                                    // any other slot becomes a hole
                                    occ_next[slot_reg] = 1'b0;
                                    dist_next          = dist_reg - LEN_W'(1);
                                    if (LEN_W'(slot_reg) + LEN_W'(1) == used_reg)
                                    begin
                                        used_next = used_reg - LEN_W'(1);
                                    end
                                    else
                                    begin
                                        holes_next = holes_reg + LEN_W'(1);
                                    end
                                end
                                else
                                begin
                                    ram_we       = 1'b1;
                                    ram_wdata    = {key_reg, cnt_dec};
                                    res_vld_next = 1'b1;
                                    res_key_next = key_reg;
                                    res_cnt_next = cnt_dec;
                                end
                            end
                        end

                        default:
                        begin
                            res_st_next = rcit_pkg::ST_OK;
                        end
                    endcase

                    res_holes_next = holes_next;
                    res_dist_next  = dist_next;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            occ_reg        <= '0;
            used_reg       <= '0;
            holes_reg      <= '0;
            dist_reg       <= '0;
            scan_idx_reg   <= '0;
            chk_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            hole_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            used_reg       <= used_next;
            holes_reg      <= holes_next;
            dist_reg       <= dist_next;
            scan_idx_reg   <= scan_idx_next;
            chk_vld_reg    <= chk_vld_next;
            found_reg      <= found_next;
            hole_found_reg <= hole_found_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        qid_reg       <= qid_next;
        chk_idx_reg   <= chk_idx_next;
        slot_reg      <= slot_next;
        hole_idx_reg  <= hole_idx_next;
        cnt_reg       <= cnt_next;
        res_id_reg    <= res_id_next;
        res_key_reg   <= res_key_next;
        res_vld_reg   <= res_vld_next;
        res_st_reg    <= res_st_next;
        res_cnt_reg   <= res_cnt_next;
        res_holes_reg <= res_holes_next;
        res_dist_reg  <= res_dist_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign result_id    = res_id_reg;
    assign result_key   = rcit_pkg::KEY_PORT_W'(res_key_reg);
    assign id_valid     = res_vld_reg;
    assign status       = res_st_reg;
    assign use_count    = rcit_pkg::COUNT_PORT_W'(res_cnt_reg);
    assign hole_count   = rcit_pkg::ID_PORT_W'(res_holes_reg);
    assign cached_count = rcit_pkg::CACHED_W'(res_dist_reg);

endmodule

[sv/rcit_checker.sv]
// Port-level assertions for the refcounted ID interning table, plus its bind.
// Depends on rcit_pkg (status codes, field widths).
module rcit_checker #(
    parameter int COUNT_BITS = 16
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               rsp_valid,
    input logic                               rsp_stall,
    input logic [rcit_pkg::ID_PORT_W-1:0]     result_id,
    input logic [rcit_pkg::KEY_PORT_W-1:0]    result_key,
    input logic                               id_valid,
    input rcit_pkg::status_t                  status,
    input logic [rcit_pkg::COUNT_PORT_W-1:0]  use_count
);

    localparam logic [rcit_pkg::COUNT_PORT_W-1:0] CNT_SAT =
        rcit_pkg::COUNT_PORT_W'({COUNT_BITS{1'b1}});

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(result_id)
            && $stable(result_key) && $stable(status) && $stable(use_count))
        else $error("stalled response changed");

    // failed cache/forget reports nothing about a slot
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == rcit_pkg::ST_NOT_FOUND || status == rcit_pkg::ST_FULL)
            |-> !id_valid && result_id == '0 && result_key == '0 && use_count == '0)
        else $error("failed op reported slot data");

    // overflow reports the held slot at its saturated count
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == rcit_pkg::ST_OVERFLOW |-> id_valid && use_count == CNT_SAT)
        else $error("overflow without saturated count");

    // an invalid slot shows no key and no count
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !id_valid |-> result_key == '0 && use_count == '0)
        else $error("invalid slot with data");

endmodule

bind refcounted_id_interning_table rcit_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_rcit_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .result_id  (result_id),
    .result_key (result_key),
    .id_valid   (id_valid),
    .status     (status),
    .use_count  (use_count)
);
